// File: rtl/abta_pkg.sv
// shared types, constants and codes for the address binding table
`timescale 1ns / 1ps
`default_nettype none
package abta_pkg;

   localparam int ENTRIES       = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RM_W          = $clog2(MAX_RESULTS + 1);
   localparam int KEY_W         = 64;
   localparam int CNT_W         = 22;
   localparam int LIFE_W        = 16;
   localparam int HOURS_DEFAULT = 24;
   localparam int STALE_RESET   = HOURS_DEFAULT * 60;
   localparam int DATA_W        = 32;
   localparam int ADDR_W        = 3;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_LOOKUP    = 3'd2;
   localparam logic [2:0] OP_REACHABLE = 3'd3;
   localparam logic [2:0] OP_STALE     = 3'd4;
   localparam logic [2:0] OP_REMOVE    = 3'd5;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_PRESENT   = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   localparam logic REG_STALE_MINUTES = 1'b0;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [LIFE_W-1:0] lifetime;
   } req_item_type;

   typedef struct packed {
      logic             found;
      logic             reachable;
      logic [1:0]       status;
      logic             removed;
      logic [KEY_W-1:0] removed_key_high;
      logic [KEY_W-1:0] removed_key_low;
      logic             last;
   } rsp_item_type;

   typedef struct packed {
      logic             reachable;
      logic             running;
      logic [CNT_W-1:0] countdown;
   } meta_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_READ,
      CTL_EVAL,
      CTL_DONE
   } ctl_state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } abta_cmd_type;

   typedef struct packed {
      logic last_idx;
      logic stall;
      logic out_free;
   } abta_status_type;

endpackage
`default_nettype wire

// File: rtl/abta_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module abta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/abta_ctrl.sv
// controller state machine sequencing the table scan
`timescale 1ns / 1ps
`default_nettype none
module abta_ctrl
   import abta_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output abta_cmd_type         cmd,
   input  wire abta_status_type status
);
   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_READ;
         end
         CTL_READ: begin
            state_in = CTL_EVAL;
         end
         CTL_EVAL: begin
            if (!status.stall) state_in = status.last_idx ? CTL_DONE : CTL_READ;
         end
         CTL_DONE: begin
            if (status.out_free) state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         CTL_EVAL: begin
            cmd.step = !status.stall;
         end
         CTL_DONE: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_EVAL && status.stall) |=> state_ff == CTL_EVAL)
      else $error("eval left while stalled");
   a_step_only_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> state_ff == CTL_EVAL)
      else $error("step outside eval");
   a_start_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == CTL_READ)
      else $error("start without read");
endmodule
`default_nettype wire

// File: rtl/abta_dp.sv
// datapath: entry storage, scan registers, aging and result register
`timescale 1ns / 1ps
`default_nettype none
module abta_dp
   import abta_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_item_type    req_data,
   input  wire logic [CNT_W-1:0] stale_minutes,
   input  wire abta_cmd_type    cmd,
   output abta_status_type      status,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_item_type         rsp_data
);
   req_item_type          req_ff;
   logic [IDX_W-1:0]      idx_ff, hit_idx_ff, free_idx_ff;
   logic                  hit_ff, hit_reach_ff, free_ff;
   logic                  pend_v_ff;
   logic [2*KEY_W-1:0]    pend_key_ff;
   logic [RM_W-1:0]       rm_cnt_ff;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic                  rsp_v_ff;
   rsp_item_type          rsp_ff, rsp_in;
   logic                  rsp_push;

   meta_type              meta_rd, meta_wd;
   logic                  meta_we;
   logic [IDX_W-1:0]      meta_wa;
   logic [2*KEY_W-1:0]    key_rd;
   logic                  key_we;

   logic                  out_free, is_tick, ent_v, act, expire, remove_now, key_match;

   abta_ram #(.WIDTH(2 * KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (free_idx_ff),
      .wr_data ({req_ff.key_high, req_ff.key_low}),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   abta_ram #(.WIDTH($bits(meta_type)), .DEPTH(ENTRIES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_wa),
      .wr_data (meta_wd),
      .rd_addr (idx_ff),
      .rd_data (meta_rd)
   );

   assign out_free   = !rsp_v_ff || rsp_ready;
   assign is_tick    = req_ff.req_type == OP_TICK;
   assign ent_v      = valid_ff[idx_ff];
   assign act        = is_tick && ent_v && meta_rd.running;
   assign expire     = meta_rd.countdown <= CNT_W'(1);
   assign remove_now = act && expire && !meta_rd.reachable && (rm_cnt_ff < RM_W'(MAX_RESULTS));
   assign key_match  = ent_v && (key_rd == {req_ff.key_high, req_ff.key_low});

   assign status.last_idx = idx_ff == IDX_W'(ENTRIES - 1);
   assign status.stall    = remove_now && pend_v_ff && !out_free;
   assign status.out_free = out_free;

   always_comb begin
      meta_we  = 1'b0;
      meta_wa  = idx_ff;
      meta_wd  = '0;
      key_we   = 1'b0;
      valid_in = valid_ff;
      rsp_push = 1'b0;
      rsp_in   = '0;
      if (cmd.step && act) begin
         if (!expire) begin
            meta_we = 1'b1;
            meta_wd = '{reachable: meta_rd.reachable, running: 1'b1,
                        countdown: meta_rd.countdown - CNT_W'(1)};
         end else if (meta_rd.reachable) begin
            meta_we = 1'b1;
            meta_wd = '{reachable: 1'b0, running: 1'b1, countdown: stale_minutes};
         end else if (remove_now) begin
            valid_in[idx_ff] = 1'b0;
            if (pend_v_ff) begin
               rsp_push                = 1'b1;
               rsp_in.removed          = 1'b1;
               rsp_in.removed_key_high = pend_key_ff[2*KEY_W-1:KEY_W];
               rsp_in.removed_key_low  = pend_key_ff[KEY_W-1:0];
            end
         end else begin
            meta_we = 1'b1;
            meta_wd = '{reachable: 1'b0, running: 1'b1, countdown: '0};
         end
      end
      if (cmd.finish) begin
         rsp_push    = 1'b1;
         rsp_in.last = 1'b1;
         meta_wa     = hit_idx_ff;
         case (req_ff.req_type)
            OP_TICK: begin
               if (pend_v_ff) begin
                  rsp_in.removed          = 1'b1;
                  rsp_in.removed_key_high = pend_key_ff[2*KEY_W-1:KEY_W];
                  rsp_in.removed_key_low  = pend_key_ff[KEY_W-1:0];
               end
            end
            OP_ADD: begin
               if (hit_ff) begin
                  rsp_in.found     = 1'b1;
                  rsp_in.reachable = hit_reach_ff;
                  rsp_in.status    = STAT_PRESENT;
               end else if (!free_ff) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  key_we                = 1'b1;
                  meta_we               = 1'b1;
                  meta_wa               = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
               end
            end
            OP_LOOKUP: begin
               if (hit_ff) begin
                  rsp_in.found     = 1'b1;
                  rsp_in.reachable = hit_reach_ff;
               end else begin
                  rsp_in.status = STAT_NOT_FOUND;
               end
            end
            OP_REACHABLE: begin
               if (hit_ff) begin
                  meta_we          = 1'b1;
                  meta_wd          = '{reachable: 1'b1,
                                       running: req_ff.lifetime != '0,
                                       countdown: {{(CNT_W - LIFE_W){1'b0}},
                                                   req_ff.lifetime}};
                  rsp_in.found     = 1'b1;
                  rsp_in.reachable = 1'b1;
               end else begin
                  rsp_in.status = STAT_NOT_FOUND;
               end
            end
            OP_STALE: begin
               if (hit_ff) begin
                  meta_we      = 1'b1;
                  meta_wd      = '{reachable: 1'b0, running: 1'b1, countdown: stale_minutes};
                  rsp_in.found = 1'b1;
               end else begin
                  rsp_in.status = STAT_NOT_FOUND;
               end
            end
            OP_REMOVE: begin
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  rsp_in.found         = 1'b1;
               end else begin
                  rsp_in.status = STAT_NOT_FOUND;
               end
            end
            default: begin
               rsp_in.last = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rsp_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         rm_cnt_ff <= '0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         if (rsp_push) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_v_ff <= 1'b0;
         end
         if (cmd.start) begin
            idx_ff    <= '0;
            hit_ff    <= 1'b0;
            free_ff   <= 1'b0;
            pend_v_ff <= 1'b0;
            rm_cnt_ff <= '0;
         end else if (cmd.step) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (remove_now) begin
               pend_v_ff <= 1'b1;
               rm_cnt_ff <= rm_cnt_ff + RM_W'(1);
            end
            if (!is_tick && key_match) begin
               hit_ff <= 1'b1;
            end
            if (!is_tick && !ent_v && !free_ff) begin
               free_ff <= 1'b1;
            end
         end else if (cmd.finish) begin
            pend_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_data;
      end
      if (cmd.step) begin
         if (remove_now) begin
            pend_key_ff <= key_rd;
         end
         if (!is_tick && key_match) begin
            hit_idx_ff   <= idx_ff;
            hit_reach_ff <= meta_rd.reachable;
         end
         if (!is_tick && !ent_v && !free_ff) begin
            free_idx_ff <= idx_ff;
         end
      end
      if (rsp_push) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   a_rm_bound: assert property (@(posedge clock) disable iff (reset)
      rm_cnt_ff <= RM_W'(MAX_RESULTS))
      else $error("removal count beyond limit");
   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> is_tick)
      else $error("pending removal outside tick");
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_v_ff && rsp_ff.last)
      else $error("finish without final result");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> out_free)
      else $error("result register overwritten");
endmodule
`default_nettype wire

// File: rtl/address_binding_table_aging.sv
// top level of the address binding table with minute aging
//
//  port group   dir   handshake               payload
//  req_         in    req_valid / req_ready   req_data  (req_item_type)
//  rsp_         out   rsp_valid / rsp_ready   rsp_data  (rsp_item_type)
//  csr (apb)    in    psel / penable / pready paddr, pwdata, prdata
//
//  one request at a time: the scan reads the entries one after another, a read state
//  then an evaluate state for each; a new request waits until the final result is registered
//  a held output stalls a tick scan at each removal after the first and holds the final result
//  reset empties the table at once through per-entry valid flip-flops
//  stale_minutes resets to 1440
`timescale 1ns / 1ps
`default_nettype none
module address_binding_table_aging
   import abta_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_item_type      req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_item_type           rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);
   logic [CNT_W-1:0] stale_ff;
   logic             reg_sel;
   abta_cmd_type     cmd;
   abta_status_type  status;

   assign pready  = 1'b1;
   assign reg_sel = paddr[ADDR_W-1:2] == REG_STALE_MINUTES;

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ff <= CNT_W'(STALE_RESET);
      end else if (psel && penable && pwrite && reg_sel) begin
         stale_ff <= pwdata[CNT_W-1:0];
      end
   end

   assign prdata = reg_sel ? {{(DATA_W - CNT_W){1'b0}}, stale_ff} : '0;

   abta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   abta_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .stale_minutes (stale_ff),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );
endmodule
`default_nettype wire

// File: test/binding_table_checker.sv
// checker: mirrors the address binding table, predicts each request's results and compares them
`timescale 1ns / 1ps
module binding_table_checker
   import abta_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire req_item_type      req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rsp_item_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic              pready,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output int                     mismatch_count,
   output int                     pending_results,
   output int                     request_count,
   output int                     removal_count,
   output int                     full_count,
   output int                     widest_sweep
);

   logic             slot_valid     [ENTRIES];
   logic [KEY_W-1:0] slot_key_high  [ENTRIES];
   logic [KEY_W-1:0] slot_key_low   [ENTRIES];
   logic             slot_reachable [ENTRIES];
   logic             slot_running   [ENTRIES];
   logic [CNT_W-1:0] slot_countdown [ENTRIES];
   logic [CNT_W-1:0] stale_minutes;
   rsp_item_type     awaited_results[$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      request_count   = 0;
      removal_count   = 0;
      full_count      = 0;
      widest_sweep    = 0;
   end

   task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                  input logic [KEY_W-1:0] got);
      mismatch_count++;
      $display("%0t ns mismatch on %s: expected %h, got %h", $time, what, want, got);
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result with no request behind it", '0, KEY_W'(got.last));
      end else begin
         want = awaited_results.pop_front();
         if (got.found !== want.found) begin
            report_mismatch("found", KEY_W'(want.found), KEY_W'(got.found));
         end
         if (got.reachable !== want.reachable) begin
            report_mismatch("reachable", KEY_W'(want.reachable), KEY_W'(got.reachable));
         end
         if (got.status !== want.status) begin
            report_mismatch("status", KEY_W'(want.status), KEY_W'(got.status));
         end
         if (got.removed !== want.removed) begin
            report_mismatch("removed", KEY_W'(want.removed), KEY_W'(got.removed));
         end
         if (got.removed_key_high !== want.removed_key_high) begin
            report_mismatch("removed_key_high", want.removed_key_high, got.removed_key_high);
         end
         if (got.removed_key_low !== want.removed_key_low) begin
            report_mismatch("removed_key_low", want.removed_key_low, got.removed_key_low);
         end
         if (got.last !== want.last) begin
            report_mismatch("last", KEY_W'(want.last), KEY_W'(got.last));
         end
      end
   endtask

   task automatic predict_binding_results(input req_item_type r);
      rsp_item_type batch[$];
      rsp_item_type item;
      int hit;
      int free_slot;
      item = '0;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && slot_key_high[i] == r.key_high && slot_key_low[i] == r.key_low
             && hit < 0) begin
            hit = i;
         end
         if (!slot_valid[i] && free_slot < 0) free_slot = i;
      end
      case (r.req_type)
         OP_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i] && slot_running[i]) begin
                  if (slot_countdown[i] > 1) begin
                     slot_countdown[i] = slot_countdown[i] - 1'b1;
                  end else if (slot_reachable[i]) begin
                     slot_reachable[i] = 1'b0;
                     slot_countdown[i] = stale_minutes;
                  end else if (batch.size() < MAX_RESULTS) begin
                     item = '0;
                     item.removed = 1'b1;
                     item.removed_key_high = slot_key_high[i];
                     item.removed_key_low = slot_key_low[i];
                     batch.push_back(item);
                     slot_valid[i] = 1'b0;
                     slot_running[i] = 1'b0;
                     slot_countdown[i] = '0;
                  end else begin
                     slot_countdown[i] = '0;
                  end
               end
            end
            item = '0;
            removal_count += batch.size();
            if (batch.size() > widest_sweep) widest_sweep = batch.size();
         end
         OP_ADD: begin
            if (hit >= 0) begin
               item.found = 1'b1;
               item.reachable = slot_reachable[hit];
               item.status = STAT_PRESENT;
            end else if (free_slot < 0) begin
               item.status = STAT_FULL;
               full_count++;
            end else begin
               slot_valid[free_slot] = 1'b1;
               slot_key_high[free_slot] = r.key_high;
               slot_key_low[free_slot] = r.key_low;
               slot_reachable[free_slot] = 1'b0;
               slot_running[free_slot] = 1'b0;
               slot_countdown[free_slot] = '0;
               item.status = STAT_OK;
            end
         end
         OP_LOOKUP, OP_REACHABLE, OP_STALE, OP_REMOVE: begin
            if (hit < 0) begin
               item.status = STAT_NOT_FOUND;
            end else begin
               item.found = 1'b1;
               item.status = STAT_OK;
               case (r.req_type)
                  OP_LOOKUP: item.reachable = slot_reachable[hit];
                  OP_REACHABLE: begin
                     slot_reachable[hit] = 1'b1;
                     slot_running[hit] = (r.lifetime != '0);
                     slot_countdown[hit] = CNT_W'(r.lifetime);
                     item.reachable = 1'b1;
                  end
                  OP_STALE: begin
                     slot_reachable[hit] = 1'b0;
                     slot_running[hit] = 1'b1;
                     slot_countdown[hit] = stale_minutes;
                  end
                  default: begin
                     slot_valid[hit] = 1'b0;
                     slot_running[hit] = 1'b0;
                     slot_countdown[hit] = '0;
                  end
               endcase
            end
         end
         default: ;
      endcase
      if (batch.size() == 0) batch.push_back(item);
      item = batch.pop_back();
      item.last = 1'b1;
      batch.push_back(item);
      foreach (batch[k]) awaited_results.push_back(batch[k]);
      request_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         stale_minutes = CNT_W'(STALE_RESET);
         awaited_results.delete();
         pending_results = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == {REG_STALE_MINUTES, 2'b00}) begin
            stale_minutes = pwdata[CNT_W-1:0];
         end
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) predict_binding_results(req_data);
         pending_results = awaited_results.size();
      end
   end

endmodule

// File: test/address_binding_table_aging_tb.sv
// testbench top: drives requests, stale-minute writes and result back-pressure
`timescale 1ns / 1ps
module address_binding_table_aging_tb;
   import abta_pkg::*;

   localparam int                CYCLE_LIMIT  = 400000;
   localparam int                POOL         = 24;
   localparam int                SWEEP        = ENTRIES + 1;
   localparam int                LONG_HOLD    = 400;
   localparam int                SETTLE       = 2 * ENTRIES + 8;
   localparam int                STALE_MAX    = 3932100;
   localparam logic [ADDR_W-1:0] STALE_ADDR   = {REG_STALE_MINUTES, 2'b00};
   localparam logic [2:0]        OP_SPARE_LO  = 3'd6;
   localparam logic [2:0]        OP_SPARE_HI  = 3'd7;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_item_type      req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_item_type      rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int mismatch_count;
   int pending_results;
   int request_count;
   int removal_count;
   int full_count;
   int widest_sweep;
   int cycle_count = 0;
   int burst_left  = 1;
   bit steady_send = 1'b0;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;
   int ready_mode  = 0;
   int mode_left   = 100;

   logic [KEY_W-1:0] pool_high  [POOL];
   logic [KEY_W-1:0] pool_low   [POOL];
   logic [KEY_W-1:0] sweep_high [SWEEP];
   logic [KEY_W-1:0] sweep_low  [SWEEP];

   address_binding_table_aging uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   binding_table_checker table_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .request_count   (request_count),
      .removal_count   (removal_count),
      .full_count      (full_count),
      .widest_sweep    (widest_sweep)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycle_count, pending_results);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: changing stall patterns plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asked > hold_served) begin
         hold_served <= hold_served + 1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_request(input logic [2:0] kind, input logic [KEY_W-1:0] kh,
                               input logic [KEY_W-1:0] kl, input logic [LIFE_W-1:0] life);
      req_item_type item;
      int gap;
      item.req_type = kind;
      item.key_high = kh;
      item.key_low = kl;
      item.lifetime = life;
      req_data <= item;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = steady_send ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_stale_minutes(input logic [CNT_W-1:0] minutes);
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= STALE_ADDR;
      pwdata <= DATA_W'(minutes);
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [LIFE_W-1:0] pick_lifetime();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: return '1;
         3: return LIFE_W'($urandom);
         default: return LIFE_W'($urandom_range(1, 4));
      endcase
   endfunction

   // adds only ever use pool keys so that a stale sweep can empty the table
   task automatic random_requests(input int count, input int add_weight);
      int roll;
      int pick;
      logic [2:0] kind;
      logic [KEY_W-1:0] kh;
      logic [KEY_W-1:0] kl;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, POOL - 1);
         kh = pool_high[pick];
         kl = pool_low[pick];
         if (roll < add_weight) kind = OP_ADD;
         else if (roll < add_weight + 30) kind = OP_TICK;
         else if (roll < add_weight + 45) kind = OP_REACHABLE;
         else if (roll < add_weight + 57) kind = OP_STALE;
         else if (roll < add_weight + 66) kind = OP_REMOVE;
         else if (roll < add_weight + 69) kind = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
         else kind = OP_LOOKUP;
         if (kind != OP_ADD && $urandom_range(0, 9) == 0) begin
            kh = {$urandom, $urandom};
            kl = {$urandom, $urandom};
         end
         send_request(kind, kh, kl, pick_lifetime());
      end
   endtask

   // with zero stale minutes this clears every pool key from the table
   task automatic drain_pool();
      for (int i = 0; i < POOL; i++) send_request(OP_STALE, pool_high[i], pool_low[i], '0);
      send_request(OP_TICK, '0, '0, '0);
   endtask

   // overfill an empty table, age every entry at once, clear them in one tick
   task automatic flood_and_sweep();
      for (int i = 0; i < SWEEP; i++) begin
         sweep_high[i] = {$urandom, $urandom};
         sweep_low[i] = {$urandom, $urandom};
         send_request(OP_ADD, sweep_high[i], sweep_low[i], '0);
      end
      for (int i = 0; i < SWEEP; i++) send_request(OP_STALE, sweep_high[i], sweep_low[i], '0);
      send_request(OP_TICK, {$urandom, $urandom}, {$urandom, $urandom}, '1);
   endtask

   initial begin
      for (int i = 0; i < POOL; i++) begin
         pool_high[i] = {$urandom, $urandom};
         pool_low[i] = {$urandom, $urandom};
      end
      pool_high[0] = '0;
      pool_low[0] = '0;
      pool_high[1] = '1;
      pool_low[1] = '1;
      pool_high[2] = pool_high[3];
      pool_low[2] = pool_low[3] ^ 64'h1;
      pool_low[4] = pool_low[5];
      pool_high[4] = pool_high[5] ^ {1'b1, 63'b0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests under the reset stale lifetime
      send_request(OP_LOOKUP, pool_high[0], pool_low[0], '0);
      send_request(OP_ADD, pool_high[0], pool_low[0], '0);
      send_request(OP_ADD, pool_high[0], pool_low[0], '1);
      send_request(OP_ADD, pool_high[1], pool_low[1], '0);
      for (int i = 2; i < 6; i++) send_request(OP_ADD, pool_high[i], pool_low[i], '0);
      send_request(OP_LOOKUP, pool_high[1], pool_low[1], '0);
      send_request(OP_REACHABLE, pool_high[1], pool_low[1], LIFE_W'(1));
      send_request(OP_REACHABLE, pool_high[0], pool_low[0], '0);
      send_request(OP_REACHABLE, pool_high[2], pool_low[2], '1);
      send_request(OP_LOOKUP, pool_high[0], pool_low[0], '0);
      send_request(OP_TICK, '1, '1, '1);
      send_request(OP_LOOKUP, pool_high[1], pool_low[1], '0);
      send_request(OP_STALE, pool_high[3], pool_low[3], '0);
      send_request(OP_REMOVE, pool_high[4], pool_low[4], '0);
      send_request(OP_REMOVE, pool_high[4], pool_low[4], '0);
      send_request(OP_REACHABLE, {$urandom, $urandom}, {$urandom, $urandom}, LIFE_W'(3));
      send_request(OP_STALE, {$urandom, $urandom}, {$urandom, $urandom}, '0);
      send_request(OP_SPARE_LO, '1, '1, '1);
      send_request(OP_SPARE_HI, '0, '0, '0);
      send_request(OP_TICK, '0, '0, '0);

      set_stale_minutes(CNT_W'(1));
      random_requests(30, 20);
      hold_asked <= hold_asked + 1;
      random_requests(60, 20);

      set_stale_minutes('0);
      drain_pool();
      flood_and_sweep();
      random_requests(60, 20);

      set_stale_minutes(CNT_W'(STALE_MAX));
      steady_send = 1'b1;
      random_requests(80, 35);
      steady_send = 1'b0;

      set_stale_minutes(CNT_W'(2));
      random_requests(90, 20);

      set_stale_minutes('0);
      drain_pool();

      set_stale_minutes(CNT_W'(STALE_RESET));
      random_requests(50, 20);

      wait_idle();
      $display("ran %0d requests across seven stale-minute settings, %0d answered table full",
               request_count, full_count);
      $display("%0d entries aged out, at most %0d cleared by a single tick",
               removal_count, widest_sweep);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
